// ===== sv/jsbe_pkg.sv =====
// ----------------------------------------------------------------------------
// jsbe_pkg
// Shared constants, types and helpers for the JSON string byte escaper.
// ----------------------------------------------------------------------------
package jsbe_pkg;

  localparam int CNT_W   = 12;
  localparam int SEQ_MAX = 6;
  localparam int IDX_W   = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 12'd4095;
  localparam logic [CNT_W:0]   SLACK     = 13'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  typedef logic [7:0]           byte_t;
  typedef byte_t [SEQ_MAX-1:0]  seq_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;

  function automatic byte_t hex_digit(input logic [3:0] nib);
    byte_t d;
    if (nib < 4'd10) begin
      d = CH_ZERO + {4'd0, nib};
    end else begin
      d = CH_LA + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

endpackage

// ===== sv/json_string_byte_escaper_core.sv =====
// ----------------------------------------------------------------------------
// json_string_byte_escaper_core
// Escapes a byte stream for a JSON string body, capacity-limited, with a
// terminator word carrying the output length.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] data_byte, tlast last_in
//  out_    | master    | tdata[7:0] out_byte, [19:8] out_length; tlast end_of_string
//  cfg_    | slave     | data[11:0] output_capacity, always ready
//
//  An input word is registered, escaped combinationally into a sequence buffer,
//  then drained at one word per cycle while out_tready is high; the escape
//  length plus the terminator gives 1 to 7 words; words that emit none skip it.
//  The next sequence loads in the cycle the previous one's final word leaves.
//  rst_n is synchronous; it clears count, stop flag and valids, and sets the
//  capacity to 4095.
// ----------------------------------------------------------------------------
module json_string_byte_escaper_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // last_in
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [7:0] out_byte, [19:8] out_length
  output logic                 out_tlast,  // end_of_string
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [jsbe_pkg::CNT_W-1:0] cfg_data  // output_capacity
);
  import jsbe_pkg::*;

  cnt_t  cap_r;
  logic  in_vld_r;
  byte_t in_data_r;
  logic  in_last_r;
  cnt_t  cnt_r, cnt_nxt;
  logic  halt_r, halt_nxt;

  logic  buf_vld_r;
  seq_t  seq_r, seq_nxt;
  idx_t  n_r, n_nxt;
  idx_t  tot_r, tot_nxt;
  idx_t  idx_r;
  cnt_t  len_r, len_nxt;

  logic  adv, out_fire, buf_free, final_word;
  logic  full;
  cnt_t  cnt_sum;

  assign cfg_ready = 1'b1;

  assign full = ({1'b0, cnt_r} + SLACK) >= {1'b0, cap_r};

  always_comb begin
    seq_nxt  = '0;
    n_nxt    = '0;
    halt_nxt = halt_r;
    if (!halt_r) begin
      if (in_data_r == CH_NUL || full) begin
        halt_nxt = 1'b1;
      end else if (in_data_r == CH_QUOTE || in_data_r == CH_BSL) begin
        seq_nxt[0] = CH_BSL;
        seq_nxt[1] = in_data_r;
        n_nxt      = 3'd2;
      end else if (in_data_r == CH_LF) begin
        seq_nxt[0] = CH_BSL;
        seq_nxt[1] = CH_N;
        n_nxt      = 3'd2;
      end else if (in_data_r < CH_SPACE || in_data_r > CH_TILDE) begin
        seq_nxt[0] = CH_BSL;
        seq_nxt[1] = CH_U;
        seq_nxt[2] = CH_ZERO;
        seq_nxt[3] = CH_ZERO;
        seq_nxt[4] = hex_digit(in_data_r[7:4]);
        seq_nxt[5] = hex_digit(in_data_r[3:0]);
        n_nxt      = 3'd6;
      end else begin
        seq_nxt[0] = in_data_r;
        n_nxt      = 3'd1;
      end
    end
    cnt_sum = cnt_r + {{(CNT_W-IDX_W){1'b0}}, n_nxt};
    tot_nxt = n_nxt + {2'd0, in_last_r};
    len_nxt = cnt_sum;
    cnt_nxt = cnt_sum;
    if (in_last_r) begin
      cnt_nxt  = '0;
      halt_nxt = 1'b0;
    end
  end

  assign out_fire   = out_tvalid && out_tready;
  assign final_word = (idx_r == tot_r - 3'd1);
  assign buf_free   = !buf_vld_r || (out_fire && final_word);
  assign adv        = in_vld_r && (tot_nxt == '0 || buf_free);
  assign in_tready  = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      in_vld_r  <= 1'b0;
      cnt_r     <= '0;
      halt_r    <= 1'b0;
      buf_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        cnt_r  <= cnt_nxt;
        halt_r <= halt_nxt;
      end
      if (adv && tot_nxt != '0) begin
        buf_vld_r <= 1'b1;
        idx_r     <= '0;
      end else if (out_fire) begin
        if (final_word) begin
          buf_vld_r <= 1'b0;
          idx_r     <= '0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (adv && tot_nxt != '0) begin
      seq_r <= seq_nxt;
      n_r   <= n_nxt;
      tot_r <= tot_nxt;
      len_r <= len_nxt;
    end
  end

  logic  term;
  byte_t cur_byte;

  assign term       = buf_vld_r && (idx_r == n_r);
  assign cur_byte   = (idx_r < n_r) ? seq_r[idx_r] : CH_NUL;
  assign out_tvalid = buf_vld_r;
  assign out_tlast  = term;
  assign out_tdata  = {4'd0, (term ? len_r : cnt_t'(0)), cur_byte};

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_vld_r |-> (idx_r < tot_r))
    else $error("sequence index past end");

  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tlast |-> (out_tdata[7:0] == CH_NUL))
    else $error("terminator byte not zero");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_vld_r && !out_fire) |=> $stable(idx_r) && buf_vld_r)
    else $error("sequence advanced without a handshake");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (cnt_r == '0) && !halt_r)
    else $error("count not cleared after terminator");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for json_string_byte_escaper_core. Drives strings of
// raw bytes under several output capacities, predicts the escaped word
// stream and terminators, and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_WORDS    = 50;

  typedef struct packed {
    byte_t data;
    logic  eos;
    cnt_t  len;
  } esc_word_t;

  class escape_scoreboard;
    cnt_t      capacity;
    cnt_t      written;
    bit        halted;
    int        failures;
    esc_word_t expected_words[$];
    string     hex_digits;

    function new();
      capacity   = CAP_RESET;
      written    = '0;
      halted     = 1'b0;
      failures   = 0;
      hex_digits = "0123456789abcdef";
    endfunction

    function void set_capacity(cnt_t value);
      capacity = value;
    endfunction

    function void note_word(byte_t b, logic last);
      byte_t     seq[$];
      esc_word_t w;
      if (!halted) begin
        if (b == CH_NUL) begin
          halted = 1'b1;
        end else if (int'(written) + int'(SLACK) >= int'(capacity)) begin
          halted = 1'b1;
        end else begin
          if (b == CH_QUOTE || b == CH_BSL) begin
            seq = '{CH_BSL, b};
          end else if (b == CH_LF) begin
            seq = '{CH_BSL, CH_N};
          end else if (b < CH_SPACE || b > CH_TILDE) begin
            seq = '{CH_BSL, CH_U, CH_ZERO, CH_ZERO,
                    byte_t'(hex_digits[b[7:4]]), byte_t'(hex_digits[b[3:0]])};
          end else begin
            seq = '{b};
          end
          written = written + cnt_t'(seq.size());
        end
      end
      foreach (seq[i]) begin
        w.data = seq[i];
        w.eos  = 1'b0;
        w.len  = '0;
        expected_words.push_back(w);
      end
      if (last) begin
        w.data = CH_NUL;
        w.eos  = 1'b1;
        w.len  = written;
        expected_words.push_back(w);
        written = '0;
        halted  = 1'b0;
      end
    endfunction

    function void check_word(logic [23:0] tdata, logic tlast);
      esc_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, actual tdata=%h tlast=%b", $time, tdata, tlast);
        failures++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (tdata[7:0] !== exp_w.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, exp_w.data, tdata[7:0]);
        failures++;
      end
      if (tlast !== exp_w.eos) begin
        $display("%0t: end_of_string expected %b actual %b", $time, exp_w.eos, tlast);
        failures++;
      end
      if (tdata[19:8] !== exp_w.len) begin
        $display("%0t: out_length expected %0d actual %0d", $time, exp_w.len, tdata[19:8]);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cnt_t        cfg_data = '0;

  escape_scoreboard sb = new();

  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  bit          stall_on = 1'b0;
  logic [15:0] stall_pat = 16'hb5a3;
  int          idle_cycles = 0;

  json_string_byte_escaper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) begin
      stall_pat <= 16'($urandom) | 16'h0001;
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    out_tready <= stall_on ? stall_pat[0] : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_word(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input byte_t b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(b, last);
  endtask

  // drop valid, let every expected word drain, then let in-flight words settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input cnt_t value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic send_string(input byte_t s[$]);
    foreach (s[i]) send_word(s[i], i == s.size() - 1);
  endtask

  function automatic byte_t random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return CH_NUL;
    if (r < 8) return CH_QUOTE;
    if (r < 11) return CH_BSL;
    if (r < 14) return CH_LF;
    if (r < 32) return byte_t'($urandom_range(1, 31));
    if (r < 52) return byte_t'($urandom_range(127, 255));
    return byte_t'($urandom_range(32, 126));
  endfunction

  initial begin
    byte_t s[$];
    int    sent;
    int    len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset capacity
    send_string('{8'h41, CH_QUOTE, CH_BSL, CH_LF, 8'h01, 8'h1f, CH_SPACE, CH_TILDE,
                  8'h7f, 8'h80, 8'hff, 8'h7a});
    send_string('{CH_NUL});
    send_string('{8'h61, CH_NUL, 8'h62});
    send_string('{8'hff});
    wait_idle();

    write_capacity(12'd1);
    send_string('{8'h61});
    wait_idle();
    write_capacity(12'd0);
    send_string('{8'h78});
    wait_idle();
    write_capacity(12'd9);
    send_string('{8'h80, 8'h61, 8'h62});
    wait_idle();
    write_capacity(12'd8);
    send_string('{8'h9c, 8'h63});
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_capacity(12'd4095);
        1: write_capacity(12'd1);
        2: write_capacity(cnt_t'($urandom_range(8, 24)));
        3: write_capacity(cnt_t'($urandom_range(2, 12)));
        4: write_capacity(cnt_t'($urandom_range(25, 120)));
        5: write_capacity(cnt_t'($urandom_range(0, 4095)));
        6: write_capacity(cnt_t'($urandom_range(7, 10)));
        default: write_capacity(cnt_t'($urandom_range(13, 40)));
      endcase
      gaps_on  = (phase != 0) && ($urandom_range(0, 3) != 0);
      stall_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(byte_t'($urandom), 1'($urandom));
          sent++;
        end else begin
          s.delete();
          len = $urandom_range(1, 20);
          for (int i = 0; i < len; i++) s.push_back(random_char());
          send_string(s);
          sent += len;
        end
      end
      wait_idle();
    end

    if (sb.failures == 0 && sb.expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
